/* hw/rtl/p10u_pkg.sv */
// Shared types and constants for the packed 10-bit pixel unpacker.
`default_nettype none

package p10u_pkg;

    localparam int BYTES_PER_GROUP = 5;
    localparam int MAX_DIM         = 2048;
    localparam int PIX_PER_GROUP   = 4;

    localparam int CNT_W     = 23;
    localparam int PIX_W     = 10;
    localparam int DIM_W     = 12;
    localparam int ADJ_W     = 7;
    localparam int PHASE_W   = 3;
    localparam int PIX_IDX_W = $clog2(PIX_PER_GROUP);

    localparam longint CNT_MAX_L   = (64'd1 << CNT_W) - 64'd1;
    localparam longint DIM_SQ_L    = longint'(MAX_DIM) * longint'(MAX_DIM);
    localparam logic [CNT_W-1:0] PIX_LIMIT =
        CNT_W'((DIM_SQ_L > CNT_MAX_L) ? CNT_MAX_L : DIM_SQ_L);
    localparam logic [CNT_W-1:0] PIX_STEP = CNT_W'(PIX_PER_GROUP);
    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(BYTES_PER_GROUP - 1);

    // item op codes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    // result kinds
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // frame status bits
    localparam int STAT_LEFTOVER = 0;
    localparam int STAT_MISMATCH = 1;

    // output formats
    localparam logic FMT_GRAY16 = 1'b0;
    localparam logic FMT_RGB888 = 1'b1;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_OUTPUT_FORMAT = 2'd0,
        CFG_FRAME_WIDTH   = 2'd1,
        CFG_FRAME_HEIGHT  = 2'd2,
        CFG_ROW_ADJUST    = 2'd3
    } cfg_index_t;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel_value;
        logic             last_of_group;
        logic [1:0]       frame_status;
        logic [CNT_W-1:0] frame_pixels;
    } out_item_t;

    typedef struct packed {
        logic                    output_format;
        logic [DIM_W-1:0]        frame_width;
        logic [DIM_W-1:0]        frame_height;
        logic signed [ADJ_W-1:0] row_adjust;
    } cfg_t;

    // one queued job: a group of four pixels or one frame status
    typedef struct packed {
        logic                                kind;
        logic [PIX_PER_GROUP-1:0][PIX_W-1:0] pix;
        logic [1:0]                          status;
        logic [CNT_W-1:0]                    count;
    } job_t;

endpackage

`default_nettype wire

/* hw/rtl/p10u_front.sv */
// Front end: byte assembly, pixel count and frame check, pushes jobs.
`default_nettype none

module p10u_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire p10u_pkg::cfg_t     cfg,
    input  wire logic               byte_valid,
    output logic                    byte_ready,
    input  wire p10u_pkg::in_item_t byte_item,
    input  wire logic               q_full,
    output logic                    push,
    output p10u_pkg::job_t          push_job
);
    import p10u_pkg::*;

    logic [31:0]        held_reg, held_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic                       accept;
    logic                       group_done;
    logic [7:0]                 b0, b1, b2, b3, b4;
    logic [PIX_W-1:0]           px0, px1, px2, px3;
    logic signed [DIM_W+1:0]    height_adj;
    logic signed [2*DIM_W+2:0]  expected;
    logic                       mismatch;

    assign byte_ready = !q_full;
    assign accept     = byte_valid && byte_ready;
    assign group_done = (byte_item.op == OP_DATA) && (phase_reg >= LAST_PHASE);
    assign push       = accept && ((byte_item.op == OP_EOF) || group_done);

    assign b0 = held_reg[31:24];
    assign b1 = held_reg[23:16];
    assign b2 = held_reg[15:8];
    assign b3 = held_reg[7:0];
    assign b4 = byte_item.data_byte;

    // big-endian 10-bit fields across the five bytes
    assign px0 = {b0, b1[7:6]};
    assign px1 = {b1[5:0], b2[7:4]};
    assign px2 = {b2[3:0], b3[7:2]};
    assign px3 = {b3[1:0], b4};

    assign height_adj = signed'({2'b00, cfg.frame_height})
                      + signed'({{(DIM_W+2-ADJ_W){cfg.row_adjust[ADJ_W-1]}}, cfg.row_adjust});
    assign expected   = signed'({1'b0, cfg.frame_width}) * height_adj;
    assign mismatch   = expected != signed'({{(2*DIM_W+3-CNT_W){1'b0}}, count_reg});

    function automatic logic [PIX_W-1:0] fmt_pix(input logic fmt, input logic [PIX_W-1:0] p);
        fmt_pix = (fmt == FMT_RGB888) ? {2'b00, p[PIX_W-1:2]} : p;
    endfunction

    always_comb
    begin
        push_job        = '0;
        push_job.kind   = KIND_PIXEL;
        push_job.pix[0] = fmt_pix(cfg.output_format, px0);
        push_job.pix[1] = fmt_pix(cfg.output_format, px1);
        push_job.pix[2] = fmt_pix(cfg.output_format, px2);
        push_job.pix[3] = fmt_pix(cfg.output_format, px3);
        if (byte_item.op == OP_EOF)
        begin
            push_job.kind                  = KIND_STATUS;
            push_job.pix                   = '0;
            push_job.status[STAT_LEFTOVER] = phase_reg != '0;
            push_job.status[STAT_MISMATCH] = mismatch;
            push_job.count                 = count_reg;
        end
    end

    always_comb
    begin
        held_next  = held_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (byte_item.op == OP_EOF)
            begin
                held_next  = '0;
                phase_next = '0;
                count_next = '0;
            end
            else if (group_done)
            begin
                held_next  = '0;
                phase_next = '0;
                count_next = (count_reg >= PIX_LIMIT - PIX_STEP) ? PIX_LIMIT
                                                                 : count_reg + PIX_STEP;
            end
            else
            begin
                held_next  = {held_reg[23:0], byte_item.data_byte};
                phase_next = phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            phase_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            held_reg  <= held_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/p10u_queue.sv */
// Two-entry job queue between front and back ends.
`default_nettype none

module p10u_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire p10u_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output p10u_pkg::job_t      head_job
);
    import p10u_pkg::*;

    job_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full       = cnt_reg == Q_CNT_W'(Q_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> !pop)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

/* hw/rtl/p10u_back.sv */
// Back end: serializes queued jobs into result items via an output register.
`default_nettype none

module p10u_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  wire p10u_pkg::job_t head_job,
    output logic                pop,
    output logic                pix_valid,
    input  wire logic           pix_ready,
    output p10u_pkg::out_item_t pix_item
);
    import p10u_pkg::*;

    logic [PIX_IDX_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg, out_item_next;
    logic                 load;
    logic                 last_piece;

    assign load       = head_valid && (!out_valid_reg || pix_ready);
    assign last_piece = (head_job.kind == KIND_STATUS)
                     || (idx_reg == PIX_IDX_W'(PIX_PER_GROUP - 1));
    assign pop        = load && last_piece;

    assign pix_valid = out_valid_reg;
    assign pix_item  = out_item_reg;

    always_comb
    begin
        out_item_next = '0;
        if (head_job.kind == KIND_STATUS)
        begin
            out_item_next.kind         = KIND_STATUS;
            out_item_next.frame_status = head_job.status;
            out_item_next.frame_pixels = head_job.count;
        end
        else
        begin
            out_item_next.kind          = KIND_PIXEL;
            out_item_next.pixel_value   = head_job.pix[idx_reg];
            out_item_next.last_of_group = idx_reg == PIX_IDX_W'(PIX_PER_GROUP - 1);
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = last_piece ? '0 : idx_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (pix_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // mid-group: the pixel job must still be at the queue head
    a_mid_group_head: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> (head_valid && head_job.kind == KIND_PIXEL))
        else $error("mid-group index without a pixel job at head");

endmodule

`default_nettype wire

/* hw/rtl/packed_10bit_ir_unpacker_core.sv */
// Top level of the packed 10-bit pixel unpacker: config registers and wiring.
`default_nettype none

// Takes one stream byte item per cycle (op 0) and turns every five bytes into
// four big-endian 10-bit pixel results; an end-of-frame item (op 1) yields one
// status result and clears the group and pixel count. Byte items are taken
// every cycle while the two-entry job queue has room; pixel results leave
// the output register at one per cycle while pix_ready is high. A job is
// written into the job queue when its last byte or end-of-frame item is
// accepted and moves on into the output register once it is free. Config
// writes (cfg_we) take effect on the next edge and must only be issued
// while the block is idle.
module packed_10bit_ir_unpacker_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       byte_valid,
    output logic                            byte_ready,
    input  wire p10u_pkg::in_item_t         byte_item,
    output logic                            pix_valid,
    input  wire logic                       pix_ready,
    output p10u_pkg::out_item_t             pix_item,
    input  wire logic                       cfg_we,
    input  wire p10u_pkg::cfg_index_t       cfg_index,
    input  wire logic [p10u_pkg::DIM_W-1:0] cfg_data
);
    import p10u_pkg::*;

    // configuration registers
    cfg_t cfg_reg, cfg_next;

    // front -> queue
    logic push;
    job_t push_job;
    logic q_full;

    // queue -> back
    logic pop;
    logic head_valid;
    job_t head_job;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_OUTPUT_FORMAT: cfg_next.output_format = cfg_data[0];
                CFG_FRAME_WIDTH:   cfg_next.frame_width   = cfg_data;
                CFG_FRAME_HEIGHT:  cfg_next.frame_height  = cfg_data;
                CFG_ROW_ADJUST:    cfg_next.row_adjust    = signed'(cfg_data[ADJ_W-1:0]);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.output_format <= FMT_GRAY16;
            cfg_reg.frame_width   <= DIM_W'(640);
            cfg_reg.frame_height  <= DIM_W'(480);
            cfg_reg.row_adjust    <= '0;
        end
        else
            cfg_reg <= cfg_next;
    end

    // front end: gathers bytes, keeps the frame count, builds jobs
    p10u_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    // decouples byte intake from result delivery
    p10u_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // back end: one result item per cycle out of the head job while the receiver is ready
    p10u_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix_item   (pix_item)
    );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the packed 10-bit pixel unpacker core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import p10u_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side
    localparam int LONG_HOLD    = 150;   // receiver back-pressure burst
    localparam int TOTAL_ITEMS  = 250;   // random phases stop once this many items went out
    localparam int DIM_ALL_ONES = (1 << DIM_W) - 1;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             byte_valid = 1'b0;
    logic             byte_ready;
    in_item_t         byte_item  = '0;
    logic             pix_valid;
    logic             pix_ready  = 1'b0;
    out_item_t        pix_item;
    logic             cfg_we     = 1'b0;
    cfg_index_t       cfg_index  = CFG_OUTPUT_FORMAT;
    logic [DIM_W-1:0] cfg_data   = '0;

    // Register mirror, reset values of the block.
    logic                    mir_format = FMT_GRAY16;
    logic [DIM_W-1:0]        mir_width  = DIM_W'(640);
    logic [DIM_W-1:0]        mir_height = DIM_W'(480);
    logic signed [ADJ_W-1:0] mir_adjust = '0;

    // Unpacker state mirror: partial group (oldest byte on top), bytes held,
    // pixels emitted in the current frame.
    logic [31:0]        grp_bytes   = '0;
    logic [PHASE_W-1:0] grp_phase   = '0;
    logic [CNT_W-1:0]   frame_count = '0;

    out_item_t   unpacked_results[$];  // pixels and frame status still to come out
    in_item_t    byte_stream[$];       // items waiting for the driver
    int          items_outstanding = 0;  // pushed but not yet accepted
    int          items_pushed      = 0;
    int unsigned fail_count        = 0;

    bit tx_gaps_on   = 1'b1;
    bit rx_gaps_on   = 1'b1;
    bit hold_request = 1'b0;
    bit byte_fire    = 1'b0;  // input handshake seen at the last rising edge
    int tx_gap       = 0;
    int rx_hold      = 0;

    packed_10bit_ir_unpacker_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix_item   (pix_item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length: mostly none, some short, a few long.
    function automatic int draw_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 75)
            return 0;
        else if (r < 96)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 24);
    endfunction

    // Signed pixel count the size check compares against.
    function automatic longint frame_size();
        return longint'(mir_width) * (longint'(mir_height) + longint'(mir_adjust));
    endfunction

    // Advance the unpacker mirror by one accepted item and queue its results.
    task automatic unpack_byte(input in_item_t it);
        logic [PIX_W-1:0] px [PIX_PER_GROUP];
        out_item_t        r;
        logic [1:0]       st;
        if (it.op == OP_DATA) begin
            if (grp_phase < LAST_PHASE) begin
                grp_bytes = {grp_bytes[23:0], it.data_byte};
                grp_phase = grp_phase + 1'b1;
            end
            else begin
                // big-endian: four 10-bit fields packed back to back across the five bytes
                px[0] = {grp_bytes[31:24], grp_bytes[23:22]};
                px[1] = {grp_bytes[21:16], grp_bytes[15:12]};
                px[2] = {grp_bytes[11:8],  grp_bytes[7:2]};
                px[3] = {grp_bytes[1:0],   it.data_byte};
                for (int i = 0; i < PIX_PER_GROUP; i++) begin
                    r               = '0;
                    r.kind          = KIND_PIXEL;
                    r.pixel_value   = (mir_format == FMT_RGB888) ? (px[i] >> 2) : px[i];
                    r.last_of_group = (i == PIX_PER_GROUP - 1);
                    unpacked_results.push_back(r);
                end
                grp_bytes = '0;
                grp_phase = '0;
                if (frame_count >= PIX_LIMIT - PIX_STEP)
                    frame_count = PIX_LIMIT;
                else
                    frame_count = frame_count + PIX_STEP;
            end
        end
        else begin
            st                = '0;
            st[STAT_LEFTOVER] = (grp_phase != 0);
            st[STAT_MISMATCH] = (longint'(frame_count) != frame_size());
            r                 = '0;
            r.kind            = KIND_STATUS;
            r.frame_status    = st;
            r.frame_pixels    = frame_count;
            unpacked_results.push_back(r);
            grp_bytes   = '0;
            grp_phase   = '0;
            frame_count = '0;
        end
    endtask

    function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (unpacked_results.size() == 0) begin
            $display("%0t: stray result, expected none, actual %h", $time, got);
            fail_count++;
        end
        else begin
            want = unpacked_results.pop_front();
            check_field("kind",          CNT_W'(want.kind),          CNT_W'(got.kind));
            check_field("pixel_value",   CNT_W'(want.pixel_value),   CNT_W'(got.pixel_value));
            check_field("last_of_group", CNT_W'(want.last_of_group),
                        CNT_W'(got.last_of_group));
            check_field("frame_status",  CNT_W'(want.frame_status),  CNT_W'(got.frame_status));
            check_field("frame_pixels",  want.frame_pixels,          got.frame_pixels);
        end
    endtask

    // Monitor: sample both handshakes at the rising edge. An input item is
    // predicted in the same edge it is taken; its results show up no earlier
    // than the next cycle, so the order of the two checks does not matter.
    always @(posedge clk)
    begin
        byte_fire = rst_n && byte_valid && byte_ready;
        if (byte_fire) begin
            unpack_byte(byte_item);
            items_outstanding--;
        end
        if (rst_n && pix_valid && pix_ready)
            check_result(pix_item);
    end

    // Driver: a new item goes out at the falling edge once the previous one
    // was taken; valid is held with a stable payload until then.
    always @(negedge clk)
    begin
        if (rst_n && (!byte_valid || byte_fire)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                byte_valid <= 1'b0;
            end
            else if (byte_stream.size() != 0) begin
                byte_item  <= byte_stream.pop_front();
                byte_valid <= 1'b1;
                tx_gap     = draw_gap(tx_gaps_on);
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request so the
    // two-entry job queue fills and the block pushes back on its input.
    always @(negedge clk)
    begin
        if (hold_request) begin
            rx_hold      = LONG_HOLD;
            hold_request = 1'b0;
        end
        else if (rx_hold == 0)
            rx_hold = draw_gap(rx_gaps_on);
        if (rx_hold != 0) begin
            pix_ready <= 1'b0;
            rx_hold--;
        end
        else
            pix_ready <= 1'b1;
    end

    // Watchdog: a hang shows up as a long run of edges with no handshake.
    initial
    begin : watchdog
        int stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge clk);
            if ((byte_valid && byte_ready) || (pix_valid && pix_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic push_data(input logic [7:0] b);
        in_item_t it;
        it.op        = OP_DATA;
        it.data_byte = b;
        byte_stream.push_back(it);
        items_outstanding++;
        items_pushed++;
    endtask

    // End of frame; the byte field is don't-care, so it gets noise.
    task automatic push_eof();
        in_item_t it;
        it.op        = OP_EOF;
        it.data_byte = 8'($urandom_range(0, 255));
        byte_stream.push_back(it);
        items_outstanding++;
        items_pushed++;
    endtask

    task automatic push_group(input logic [39:0] g);
        for (int i = 4; i >= 0; i--)
            push_data(g[i*8 +: 8]);
    endtask

    // Let everything drain: all items taken, all results seen, then a wait on
    // further falling edges for any byte still settling inside the block.
    task automatic settle();
        while (items_outstanding != 0 || unpacked_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic reg_write(input cfg_index_t idx, input logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    // Writes every register back to back; only called while the block is idle.
    task automatic set_config(input logic fmt, input int w, input int h, input int adj);
        reg_write(CFG_OUTPUT_FORMAT, DIM_W'(fmt));
        reg_write(CFG_FRAME_WIDTH,   DIM_W'(w));
        reg_write(CFG_FRAME_HEIGHT,  DIM_W'(h));
        reg_write(CFG_ROW_ADJUST,    DIM_W'(adj));
        @(negedge clk);
        cfg_we     <= 1'b0;
        mir_format = fmt;
        mir_width  = DIM_W'(w);
        mir_height = DIM_W'(h);
        mir_adjust = ADJ_W'(adj);
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 1;
            2:       return MAX_DIM;
            default: return DIM_ALL_ONES;
        endcase
    endfunction

    // Mostly small frames whose size can come out exact; now and then the
    // register extremes, where frames mostly mismatch.
    task automatic random_config();
        logic fmt;
        int   w;
        int   rows;
        int   adj;
        fmt = ($urandom_range(0, 1) != 0) ? FMT_RGB888 : FMT_GRAY16;
        if ($urandom_range(0, 5) == 0)
            set_config(fmt, pick_dim(), pick_dim(), ($urandom_range(0, 1) != 0) ? 8 : -64);
        else begin
            w    = $urandom_range(1, 6);
            rows = 4 * $urandom_range(1, 2);
            adj  = int'($urandom_range(0, 64 + ((rows < 8) ? rows : 8))) - 64;
            set_config(fmt, w, rows - adj, adj);
        end
    endtask

    // One frame: whole groups matching the expected size most of the time,
    // otherwise a random byte count or a frame a few bytes short or long.
    task automatic push_frame();
        longint due;
        int     nbytes;
        int     pick;
        due  = frame_size();
        pick = $urandom_range(0, 9);
        if (due >= 0 && due % 4 == 0 && due <= 64)
            nbytes = int'(due / 4) * 5;
        else
            nbytes = 5 * $urandom_range(0, 3);
        if (pick == 7 || pick == 8)
            nbytes = $urandom_range(0, 14);
        else if (pick == 9)
            nbytes = (nbytes > 3 && $urandom_range(0, 1) != 0) ?
                     nbytes - int'($urandom_range(1, 3)) : nbytes + int'($urandom_range(1, 3));
        repeat (nbytes) push_data(8'($urandom_range(0, 255)));
        push_eof();
    endtask

    initial
    begin : stimulus
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings (gray16, 640x480): full-scale, zero and mixed bit
        // groups, then a short frame, a frame with leftover bytes and an
        // empty frame.
        push_group(40'hFF_FF_FF_FF_FF);
        push_group(40'h00_00_00_00_00);
        push_group(40'hA5_5A_C3_3C_96);
        push_eof();
        push_data(8'h12);
        push_data(8'h34);
        push_eof();
        push_eof();
        settle();

        // One row of four in rgb888: an exact frame.
        set_config(FMT_RGB888, 4, 1, 0);
        push_group(40'hFF_C0_3F_F0_0F);
        push_eof();
        settle();

        // Zero expected size matches an empty frame.
        set_config(FMT_RGB888, 0, 480, 0);
        push_eof();
        settle();

        // Height plus adjustment below zero: always a size mismatch.
        set_config(FMT_GRAY16, 4, 1, -64);
        push_group(40'h0F_F0_3F_C0_FF);
        push_eof();
        settle();

        // Out-of-range width and height at the top of the field.
        set_config(FMT_GRAY16, DIM_ALL_ONES, DIM_ALL_ONES, 8);
        push_data(8'h5A);
        push_eof();
        settle();

        // Back-pressure: the sender streams without gaps while the receiver
        // holds off for a long stretch.
        random_config();
        tx_gaps_on   = 1'b0;
        hold_request = 1'b1;
        repeat (40) push_data(8'($urandom_range(0, 255)));
        push_eof();
        settle();
        tx_gaps_on = 1'b1;

        // Random phases; each ends with the sender paused until all results
        // are in, so the next register writes land on an idle block.
        while (items_pushed < TOTAL_ITEMS) begin
            random_config();
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3)) push_frame();
            settle();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && unpacked_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/p10u_pkg.sv
hw/rtl/p10u_front.sv
hw/rtl/p10u_queue.sv
hw/rtl/p10u_back.sv
hw/rtl/packed_10bit_ir_unpacker_core.sv
test/tb_top.sv
